/* sv/prld_pkg.sv */
// ----------------------------------------------------------------------------
// prld_pkg: shared types and constants for the pixel recolor block
// Field widths, register indexes, link-detect thresholds and the
// per-stage load enables shared by the top level and the channel lanes.
// ----------------------------------------------------------------------------
package prld_pkg;

  localparam int unsigned MaxSkipRectsDef = 4;
  localparam int unsigned CoordBitsDef    = 15;

  localparam int unsigned PosBits   = 15;
  localparam int unsigned ChanBits  = 8;
  localparam int unsigned ColorBits = 24;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 60;
  localparam int unsigned CntW     = 3;

  localparam logic [CfgIdxW-1:0] RegTextColor = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBackColor = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLinkColor = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSkipRect0 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRectCount = 3'd7;

  localparam logic [ChanBits:0] LinkMargin  = 9'd25;
  localparam logic [ChanBits-1:0] LinkMinBlue = 8'd72;
  localparam int unsigned LinkMaxLum = 230;
  localparam int unsigned LumDiv     = 3;
  localparam logic [ChanBits+1:0] LumSumMax = 10'(LinkMaxLum * LumDiv + LumDiv - 1);

  localparam int unsigned ProdW = 18;
  localparam logic signed [ProdW-1:0] RoundBias = 18'sd128;

  localparam logic [ColorBits-1:0] BackColorRst = 24'hffffff;

  localparam int unsigned UserLinkBit = 0;
  localparam int unsigned UserSkipBit = 1;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } stage_en_t;

endpackage

/* sv/prld_chan_lane.sv */
// ----------------------------------------------------------------------------
// prld_chan_lane: one color channel of the text-to-background map
// Multiplies the channel by (back - text), rounds by 255 with two signed
// shifts over two register stages, and adds the text color.
// ----------------------------------------------------------------------------
module prld_chan_lane (
  input  logic                              clk_i,
  input  prld_pkg::stage_en_t               en_i,
  input  logic [prld_pkg::ChanBits-1:0]     chan_i,
  input  logic [prld_pkg::ChanBits-1:0]     text_i,
  input  logic [prld_pkg::ChanBits-1:0]     back_i,
  output logic [prld_pkg::ChanBits-1:0]     mapped_o
);

  logic signed [prld_pkg::ChanBits:0]   diff;
  logic signed [prld_pkg::ProdW-1:0]    chan_ext, diff_ext;
  logic signed [prld_pkg::ProdW-1:0]    prod_d, prod_q;
  logic signed [prld_pkg::ProdW-1:0]    biased;
  logic signed [prld_pkg::ProdW-1:0]    round_d, round_q;

  assign diff     = $signed({1'b0, back_i}) - $signed({1'b0, text_i});
  assign chan_ext = {{(prld_pkg::ProdW-prld_pkg::ChanBits){1'b0}}, chan_i};
  assign diff_ext = {{(prld_pkg::ProdW-prld_pkg::ChanBits-1){diff[prld_pkg::ChanBits]}}, diff};
  assign prod_d   = chan_ext * diff_ext;

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      prod_q <= prod_d;
    end
  end

  assign biased  = prod_q + prld_pkg::RoundBias;
  assign round_d = biased + (biased >>> 8);

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      round_q <= round_d;
    end
  end

  // low byte of text + floor(round / 256)
  assign mapped_o = text_i + round_q[2*prld_pkg::ChanBits-1:prld_pkg::ChanBits];

endmodule

/* sv/pixel_recolor_with_link_detect_unit.sv */
// ----------------------------------------------------------------------------
// pixel_recolor_with_link_detect_unit: pixel recolor with link detection
// Input stream s_axis carries one pixel and its position per transfer;
// output stream m_axis carries the recolored pixel and two flags in tuser.
// A pixel inside an enabled skip rectangle passes unchanged; a link-blue
// pixel takes the link color when one is set; any other pixel maps each
// channel from the text color (0) to the background color (255).
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i while
// the stream is idle; each write takes effect at the next clock edge.
// An input transfer passes through a compare and multiply stage, a
// rounding stage, and the output register before it reaches m_axis.
// Throughput is one pixel per clock unless the output stalls, set by the
// three per-channel multipliers that each take a new operand every cycle.
// Each stage loads when it is empty or the stage after it moves, so the
// input keeps taking pixels while a result waits, until all stages fill.
// A stalled receiver holds the output transfer and back-pressures the
// input once the pipeline is full. Reset empties the pipeline and
// returns the registers to text black, background white, no link color
// and no skip rectangles.
// ----------------------------------------------------------------------------
module pixel_recolor_with_link_detect_unit #(
  parameter int unsigned MAX_SKIP_RECTS = prld_pkg::MaxSkipRectsDef,
  parameter int unsigned COORD_BITS     = prld_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pos_x[14:0], pos_y[29:15], in_blue[37:30], in_green[45:38], in_red[53:46]
  input  logic [prld_pkg::InDataW-1:0]        s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // out_blue[7:0], out_green[15:8], out_red[23:16]
  output logic [prld_pkg::OutDataW-1:0]       m_axis_tdata,
  // was_link[0], was_skipped[1]
  output logic [prld_pkg::OutUserW-1:0]       m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [prld_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [prld_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned RectStore = (MAX_SKIP_RECTS > 0) ? MAX_SKIP_RECTS : 1;
  localparam int unsigned RectW     = 4 * COORD_BITS;
  localparam int unsigned CB        = prld_pkg::ChanBits;

  // configuration registers
  logic [prld_pkg::ColorBits-1:0] text_q, back_q, link_q;
  logic [prld_pkg::CntW-1:0]      cnt_q;
  logic [RectStore-1:0]           hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q <= '0;
      back_q <= prld_pkg::BackColorRst;
      link_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prld_pkg::RegTextColor: text_q <= cfg_data_i[prld_pkg::ColorBits-1:0];
        prld_pkg::RegBackColor: back_q <= cfg_data_i[prld_pkg::ColorBits-1:0];
        prld_pkg::RegLinkColor: link_q <= cfg_data_i[prld_pkg::ColorBits-1:0];
        prld_pkg::RegRectCount: cnt_q  <= cfg_data_i[prld_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [COORD_BITS-1:0] px, py;
  logic [CB-1:0]         in_b, in_g, in_r;

  assign px   = s_axis_tdata[COORD_BITS-1:0];
  assign py   = s_axis_tdata[prld_pkg::PosBits +: COORD_BITS];
  assign in_b = s_axis_tdata[2*prld_pkg::PosBits +: CB];
  assign in_g = s_axis_tdata[2*prld_pkg::PosBits + CB +: CB];
  assign in_r = s_axis_tdata[2*prld_pkg::PosBits + 2*CB +: CB];

  // skip rectangles and containment
  for (genvar s = 0; s < RectStore; s++) begin : g_rect
    localparam logic [prld_pkg::CfgIdxW-1:0] SlotIdx =
      prld_pkg::CfgIdxW'(prld_pkg::RegSkipRect0 + s);
    localparam logic [prld_pkg::CntW-1:0] SlotNum = prld_pkg::CntW'(s);

    logic [RectW-1:0]      rect_q;
    logic [COORD_BITS-1:0] rx, ry, rw, rh;
    logic                  slot_on;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rect_q <= '0;
      end else if (cfg_we_i && cfg_index_i == SlotIdx && MAX_SKIP_RECTS > s) begin
        rect_q <= cfg_data_i[RectW-1:0];
      end
    end

    assign rx = rect_q[0 +: COORD_BITS];
    assign ry = rect_q[COORD_BITS +: COORD_BITS];
    assign rw = rect_q[2*COORD_BITS +: COORD_BITS];
    assign rh = rect_q[3*COORD_BITS +: COORD_BITS];
    assign slot_on = (MAX_SKIP_RECTS > s) && (cnt_q > SlotNum);

    assign hit[s] = slot_on && (px >= rx) && (py >= ry)
                  && ({1'b0, px} <= {1'b0, rx} + {1'b0, rw})
                  && ({1'b0, py} <= {1'b0, ry} + {1'b0, rh});
  end

  // link-blue test
  logic [CB-1:0]   max_rg;
  logic [CB+1:0]   lum_sum;
  logic            link_d;

  assign max_rg  = (in_r > in_g) ? in_r : in_g;
  assign lum_sum = {2'b00, in_b} + {2'b00, in_g} + {2'b00, in_r};
  assign link_d  = (link_q != '0)
                 && ({1'b0, in_b} >= {1'b0, max_rg} + prld_pkg::LinkMargin)
                 && (in_b >= prld_pkg::LinkMinBlue)
                 && (lum_sum <= prld_pkg::LumSumMax);

  // stage enables
  prld_pkg::stage_en_t en;
  logic va_q, vb_q, vo_q;
  logic en_o;

  assign en_o       = !vo_q || m_axis_tready;
  assign en.en_b    = !vb_q || en_o;
  assign en.en_a    = !va_q || en.en_b;
  assign s_axis_tready = en.en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en.en_a) va_q <= s_axis_tvalid;
      if (en.en_b) vb_q <= va_q;
      if (en_o)    vo_q <= vb_q;
    end
  end

  // stage A and B payload
  logic [prld_pkg::ColorBits-1:0] pix_a_q, pix_b_q;
  logic [RectStore-1:0]           hit_a_q;
  logic                           link_a_q, link_b_q, skip_b_q;

  always_ff @(posedge clk_i) begin
    if (en.en_a) begin
      pix_a_q  <= {in_r, in_g, in_b};
      hit_a_q  <= hit;
      link_a_q <= link_d;
    end
    if (en.en_b) begin
      pix_b_q  <= pix_a_q;
      skip_b_q <= |hit_a_q;
      link_b_q <= link_a_q;
    end
  end

  // channel lanes: blue, green, red
  logic [CB-1:0] map_b, map_g, map_r;

  prld_chan_lane u_lane_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (in_b),
    .text_i  (text_q[2*CB +: CB]),
    .back_i  (back_q[2*CB +: CB]),
    .mapped_o(map_b)
  );

  prld_chan_lane u_lane_g (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (in_g),
    .text_i  (text_q[CB +: CB]),
    .back_i  (back_q[CB +: CB]),
    .mapped_o(map_g)
  );

  prld_chan_lane u_lane_r (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (in_r),
    .text_i  (text_q[0 +: CB]),
    .back_i  (back_q[0 +: CB]),
    .mapped_o(map_r)
  );

  // output register
  logic [prld_pkg::OutDataW-1:0] odata_d, odata_q;
  logic [prld_pkg::OutUserW-1:0] ouser_d, ouser_q;

  always_comb begin
    ouser_d = '0;
    if (skip_b_q) begin
      odata_d = pix_b_q;
      ouser_d[prld_pkg::UserSkipBit] = 1'b1;
    end else if (link_b_q) begin
      odata_d = {link_q[0 +: CB], link_q[CB +: CB], link_q[2*CB +: CB]};
      ouser_d[prld_pkg::UserLinkBit] = 1'b1;
    end else begin
      odata_d = {map_r, map_g, map_b};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      odata_q <= odata_d;
      ouser_q <= ouser_d;
    end
  end

  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tvalid = vo_q;

`ifndef SYNTHESIS
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> !(ouser_q[prld_pkg::UserLinkBit] && ouser_q[prld_pkg::UserSkipBit]))
    else $error("link and skip flags both set");

  a_stage_a_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && vb_q && vo_q && !m_axis_tready) |=> va_q)
    else $error("stage A item lost during stall");

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && vb_q && vo_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full and stalled");

  a_bubble_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && !vb_q) |=> vb_q)
    else $error("stage B bubble not filled");
`endif

endmodule

/* tb/tb_pixel_recolor_with_link_detect_unit.sv */
// ----------------------------------------------------------------------------
// tb_pixel_recolor_with_link_detect_unit: pixel recolor block testbench
// Walks a directed table (reset colors, inverted colors, link-blue edges,
// skip rectangle edges and an oversized rectangle count), then runs random
// phases, each with a fresh register set. Every input transfer pushes the
// expected recolored pixel; every output transfer is checked field by field
// against the oldest one. Both stream sides idle at random, and one phase
// holds the output off long enough to back-pressure the input.
// ----------------------------------------------------------------------------
module tb_pixel_recolor_with_link_detect_unit;

  localparam int CycleLimit  = 600000;
  localparam int ResetCycles = 6;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 100;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 8;
  localparam int RectLimit   = 4;
  localparam int BlueMargin  = 25;
  localparam int BlueFloor   = 72;
  localparam int LumCeiling  = 230;

  typedef struct packed {
    logic [prld_pkg::OutUserW-1:0] user;
    logic [prld_pkg::OutDataW-1:0] data;
  } pixel_out_t;

  typedef struct packed {
    bit                            is_reg;
    logic [prld_pkg::CfgIdxW-1:0]  idx;
    logic [prld_pkg::CfgDataW-1:0] val;
    logic [prld_pkg::InDataW-1:0]  pix;
    bit                            typed;
    pixel_out_t                    res;
  } step_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic [prld_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [prld_pkg::OutDataW-1:0] m_axis_tdata;
  logic [prld_pkg::OutUserW-1:0] m_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic                          cfg_we_i;
  logic [prld_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [prld_pkg::CfgDataW-1:0] cfg_data_i;

  logic [prld_pkg::ColorBits-1:0] text_color = '0;
  logic [prld_pkg::ColorBits-1:0] back_color = prld_pkg::BackColorRst;
  logic [prld_pkg::ColorBits-1:0] link_color = '0;
  logic [prld_pkg::CfgDataW-1:0]  skip_rect [RectLimit];
  logic [prld_pkg::CntW-1:0]      skip_cnt = '0;

  pixel_out_t recolor_q [$];
  step_t      plan [$];
  int         fault_count = 0;
  int         cycle_cnt = 0;
  bit         sender_gaps = 1'b1;
  bit         receiver_gaps = 1'b1;
  bit         hold_req = 1'b0;
  pixel_out_t want_px;
  logic [7:0] want [5];
  logic [7:0] got [5];
  string      field_name [5] = '{"out_blue", "out_green", "out_red", "was_link", "was_skipped"};

  pixel_recolor_with_link_detect_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [prld_pkg::InDataW-1:0] pack_pixel(int x, int y, int b, int g,
                                                               int r);
    return {2'b00, 8'(r), 8'(g), 8'(b), 15'(y), 15'(x)};
  endfunction

  function automatic logic [prld_pkg::CfgDataW-1:0] pack_rect(int x, int y, int w, int h);
    return {15'(h), 15'(w), 15'(y), 15'(x)};
  endfunction

  function automatic pixel_out_t make_out(int b, int g, int r, bit link, bit skip);
    pixel_out_t o;
    o.data = {8'(r), 8'(g), 8'(b)};
    o.user = '0;
    o.user[prld_pkg::UserLinkBit] = link;
    o.user[prld_pkg::UserSkipBit] = skip;
    return o;
  endfunction

  function automatic logic [7:0] map_lane(logic [7:0] c, logic [7:0] t, logic [7:0] bk);
    int span;
    int n;
    span = int'(bk) - int'(t);
    n = int'(c) * span + 128;
    n = n + (n >>> 8);
    return 8'(int'(t) + (n >>> 8));
  endfunction

  function automatic pixel_out_t recolor_pixel(logic [prld_pkg::InDataW-1:0] d);
    int px, py, b, g, r, mx, lim;
    bit hit;
    px  = d[14:0];
    py  = d[29:15];
    b   = d[37:30];
    g   = d[45:38];
    r   = d[53:46];
    lim = (skip_cnt > RectLimit) ? RectLimit : skip_cnt;
    hit = 1'b0;
    for (int i = 0; i < lim; i++) begin
      if (px >= int'(skip_rect[i][14:0]) &&
          px <= int'(skip_rect[i][14:0]) + int'(skip_rect[i][44:30]) &&
          py >= int'(skip_rect[i][29:15]) &&
          py <= int'(skip_rect[i][29:15]) + int'(skip_rect[i][59:45])) begin
        hit = 1'b1;
      end
    end
    if (hit) return make_out(b, g, r, 1'b0, 1'b1);
    mx = (r > g) ? r : g;
    if (link_color != '0 && b >= mx + BlueMargin && b >= BlueFloor &&
        (b + g + r) / 3 <= LumCeiling) begin
      return make_out(link_color[23:16], link_color[15:8], link_color[7:0], 1'b1, 1'b0);
    end
    return make_out(map_lane(8'(b), text_color[23:16], back_color[23:16]),
                    map_lane(8'(g), text_color[15:8], back_color[15:8]),
                    map_lane(8'(r), text_color[7:0], back_color[7:0]), 1'b0, 1'b0);
  endfunction

  function automatic int idle_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [prld_pkg::InDataW-1:0] random_pixel();
    int x, y, b, g, r, s;
    logic [prld_pkg::CfgDataW-1:0] rc;
    if ($urandom_range(0, 1)) begin
      s  = $urandom_range(0, RectLimit - 1);
      rc = skip_rect[s];
      x  = int'(rc[14:0]) + $urandom_range(0, int'(rc[44:30]) + 4) - 2;
      y  = int'(rc[29:15]) + $urandom_range(0, int'(rc[59:45]) + 4) - 2;
    end else begin
      x = $urandom_range(0, 32767);
      y = $urandom_range(0, 32767);
    end
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(BlueFloor, 255);
        g = $urandom_range(0, b - BlueMargin + 1);
        r = $urandom_range(0, b - BlueMargin + 1);
      end
      1: begin
        b = $urandom_range(0, 1) * 255;
        g = $urandom_range(0, 1) * 255;
        r = $urandom_range(0, 255);
      end
      default: begin
        b = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end
    endcase
    return pack_pixel(x, y, b, g, r);
  endfunction

  function automatic step_t reg_row(logic [prld_pkg::CfgIdxW-1:0] idx,
                                    logic [prld_pkg::CfgDataW-1:0] v);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = v;
    return s;
  endfunction

  function automatic step_t pix_row(logic [prld_pkg::InDataW-1:0] d);
    step_t s;
    s = '0;
    s.pix = d;
    return s;
  endfunction

  function automatic step_t chk_row(logic [prld_pkg::InDataW-1:0] d, pixel_out_t o);
    step_t s;
    s = pix_row(d);
    s.typed = 1'b1;
    s.res = o;
    return s;
  endfunction

  task automatic send_pixel(logic [prld_pkg::InDataW-1:0] d, bit typed, pixel_out_t res);
    int gap;
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (s_axis_tready !== 1'b1);
    recolor_q.push_back(typed ? res : recolor_pixel(d));
    gap = sender_gaps ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (recolor_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [prld_pkg::CfgIdxW-1:0] idx,
                           logic [prld_pkg::CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    case (idx)
      prld_pkg::RegTextColor: text_color = v[prld_pkg::ColorBits-1:0];
      prld_pkg::RegBackColor: back_color = v[prld_pkg::ColorBits-1:0];
      prld_pkg::RegLinkColor: link_color = v[prld_pkg::ColorBits-1:0];
      prld_pkg::RegRectCount: skip_cnt   = v[prld_pkg::CntW-1:0];
      default:                skip_rect[idx - prld_pkg::RegSkipRect0] = v;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (recolor_q.size() == 0) begin
        fault_count = fault_count + 1;
        if (fault_count <= 40)
          $display("%0t: unexpected transfer, expected none, actual tdata=%h tuser=%b",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want_px = recolor_q.pop_front();
        want = '{want_px.data[7:0], want_px.data[15:8], want_px.data[23:16],
                 8'(want_px.user[prld_pkg::UserLinkBit]),
                 8'(want_px.user[prld_pkg::UserSkipBit])};
        got  = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                 8'(m_axis_tuser[prld_pkg::UserLinkBit]),
                 8'(m_axis_tuser[prld_pkg::UserSkipBit])};
        for (int f = 0; f < 5; f++) begin
          if (got[f] !== want[f]) begin
            fault_count = fault_count + 1;
            if (fault_count <= 40)
              $display("%0t: %s mismatch, expected %0h, actual %0h",
                       $time, field_name[f], want[f], got[f]);
          end
        end
      end
    end
  end

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = LongHold;
      end else begin
        gap = receiver_gaps ? idle_len() : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [prld_pkg::ColorBits-1:0] tc, bc, lc;
    int cnt;
    bit big;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    for (int i = 0; i < RectLimit; i++) skip_rect[i] = '0;

    plan.push_back(chk_row(pack_pixel(0, 0, 0, 0, 0), make_out(0, 0, 0, 0, 0)));
    plan.push_back(chk_row(pack_pixel(32767, 32767, 255, 255, 255),
                           make_out(255, 255, 255, 0, 0)));
    plan.push_back(chk_row(pack_pixel(5, 9, 200, 0, 0), make_out(200, 0, 0, 0, 0)));
    plan.push_back(reg_row(prld_pkg::RegTextColor, 60'hffffff));
    plan.push_back(reg_row(prld_pkg::RegBackColor, 60'h0));
    plan.push_back(chk_row(pack_pixel(1, 2, 0, 0, 0), make_out(255, 255, 255, 0, 0)));
    plan.push_back(chk_row(pack_pixel(3, 4, 255, 255, 255), make_out(0, 0, 0, 0, 0)));
    plan.push_back(pix_row(pack_pixel(6, 7, 128, 64, 1)));
    plan.push_back(reg_row(prld_pkg::RegLinkColor, 60'h123456));
    plan.push_back(chk_row(pack_pixel(10, 10, 72, 47, 47), make_out('h12, 'h34, 'h56, 1, 0)));
    plan.push_back(pix_row(pack_pixel(10, 11, 72, 48, 0)));
    plan.push_back(pix_row(pack_pixel(10, 12, 71, 0, 0)));
    plan.push_back(chk_row(pack_pixel(10, 13, 255, 230, 207),
                           make_out('h12, 'h34, 'h56, 1, 0)));
    plan.push_back(pix_row(pack_pixel(10, 14, 255, 230, 208)));
    plan.push_back(reg_row(prld_pkg::RegSkipRect0, pack_rect(100, 200, 0, 0)));
    plan.push_back(reg_row(prld_pkg::RegRectCount, 60'd1));
    plan.push_back(chk_row(pack_pixel(100, 200, 90, 10, 10), make_out(90, 10, 10, 0, 1)));
    plan.push_back(pix_row(pack_pixel(101, 200, 90, 10, 10)));
    plan.push_back(pix_row(pack_pixel(100, 201, 90, 10, 10)));
    plan.push_back(pix_row(pack_pixel(99, 200, 30, 40, 50)));
    plan.push_back(pix_row(pack_pixel(100, 199, 30, 40, 50)));
    plan.push_back(reg_row(prld_pkg::RegSkipRect0 + 3'd1,
                           pack_rect(32767, 32767, 32767, 32767)));
    plan.push_back(reg_row(prld_pkg::RegRectCount, 60'd2));
    plan.push_back(chk_row(pack_pixel(32767, 32767, 200, 20, 20),
                           make_out(200, 20, 20, 0, 1)));
    plan.push_back(pix_row(pack_pixel(32766, 32767, 200, 20, 20)));
    plan.push_back(reg_row(prld_pkg::RegRectCount, 60'd7));
    plan.push_back(chk_row(pack_pixel(0, 0, 255, 0, 0), make_out(255, 0, 0, 0, 1)));
    plan.push_back(pix_row(pack_pixel(1, 0, 255, 0, 0)));
    plan.push_back(pix_row(pack_pixel(0, 1, 17, 34, 51)));
    plan.push_back(reg_row(prld_pkg::RegRectCount, 60'd0));
    plan.push_back(pix_row(pack_pixel(100, 200, 90, 10, 10)));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_reg) begin
        wait_drain();
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        send_pixel(plan[k].pix, plan[k].typed, plan[k].res);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      wait_drain();
      tc = $urandom;
      bc = $urandom;
      case (p % 4)
        0: begin
          tc = '0;
          bc = 24'hffffff;
        end
        1: begin
          tc = 24'hffffff;
          bc = '0;
        end
        2: bc = tc;
        default: ;
      endcase
      lc = (p == 3) ? 24'h0 : (p == 5) ? 24'hffffff : 24'($urandom);
      write_reg(prld_pkg::RegTextColor, {36'($urandom), tc});
      write_reg(prld_pkg::RegBackColor, {36'($urandom), bc});
      write_reg(prld_pkg::RegLinkColor, {36'($urandom), lc});
      big = (p == 2);
      for (int i = 0; i < RectLimit; i++) begin
        write_reg(prld_pkg::RegSkipRect0 + prld_pkg::CfgIdxW'(i),
                  pack_rect($urandom_range(0, 32767), $urandom_range(0, 32767),
                            big ? $urandom_range(0, 32767) : $urandom_range(0, 200),
                            big ? $urandom_range(0, 32767) : $urandom_range(0, 200)));
      end
      cnt = (p == 0) ? 0 : (p == 1) ? 7 : (p == 7) ? 4 : $urandom_range(1, 6);
      write_reg(prld_pkg::RegRectCount, {57'({$urandom, $urandom}), 3'(cnt)});
      sender_gaps   = (p != 4) && (p != 6);
      receiver_gaps = (p != 6);
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) send_pixel(random_pixel(), 1'b0, '0);
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
